/* src/olt_pkg.sv */
// Shared types and codes for the ordered array table.
// No dependencies; every other file in src refers to it by scoped names.
package olt_pkg;

  // Widths fixed by the command and result fields
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned ModeW = 3;
  localparam int unsigned StatW = 3;

  // Command codes
  typedef enum logic [ModeW-1:0] {
    ModeClear   = 3'd0,
    ModeAppend  = 3'd1,
    ModeDisplay = 3'd2,
    ModeInsAt   = 3'd3,
    ModeDelAt   = 3'd4,
    ModeSortIns = 3'd5,
    ModeDelVal  = 3'd6
  } mode_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StatOk       = 3'd0,
    StatFull     = 3'd1,
    StatEmpty    = 3'd2,
    StatBadPos   = 3'd3,
    StatNotFound = 3'd4
  } status_e;

  // One access to the entry memory; the sequencer never reads and writes together
  typedef struct packed {
    logic             re;
    logic [IdxW-1:0]  raddr;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [WordW-1:0] wdata;
  } mem_req_t;

  // Result fields waiting to be loaded into the output register
  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] value;
    logic [IdxW-1:0]  where;
    logic             last;
  } res_t;

endpackage

/* src/ordered_array_table.sv */
// Ordered array table: a packed table of signed 32-bit words with a count.
// Depends on olt_pkg, olt_mem and olt_seq.
//
// Use: command beats come in on in_valid_i/in_stall_o with mode_i, position_i
// and element_i; one beat is taken when in_valid_i is high and in_stall_o low.
// Result beats leave on out_valid_o/out_stall_i with status_o, value_o,
// where_o, count_o and last_o. Display of a non-empty table gives one beat
// per entry with last_o on the final one, the unused mode code gives none,
// and every other command gives one result beat. The capacity register is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the table is idle, as the block does not enforce this; it resets to 16.
// Clear and append go straight to the result; display reads, captures and
// emits each entry in turn; insert at p and sorted insert fetch and write each
// entry shifted up; delete reads and compares each entry searched, then reads
// and writes each shifted down, a step at a time through the one port pair.
// Reset empties the table at once (no clearing pass); entry contents are
// left as they are. A stalled receiver holds the result beat and the
// sequencer waits for the register to free; input stays stalled until the
// command has delivered its last beat to the result register.
module ordered_array_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [olt_pkg::IdxW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [olt_pkg::ModeW-1:0]   mode_i,
  input  logic [olt_pkg::IdxW-1:0]    position_i,
  input  logic [olt_pkg::WordW-1:0]   element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [olt_pkg::StatW-1:0]   status_o,
  output logic [olt_pkg::WordW-1:0]   value_o,
  output logic [olt_pkg::IdxW-1:0]    where_o,
  output logic [olt_pkg::IdxW-1:0]    count_o,
  output logic                        last_o
);

  logic [olt_pkg::IdxW-1:0]  cap_q, cap_d;
  logic [olt_pkg::IdxW-1:0]  limit;
  olt_pkg::mem_req_t         req;
  logic [olt_pkg::WordW-1:0] rdata;

  // Take a capacity write
  always_comb begin
    cap_d = cap_q;
    if (cfg_we_i) begin
      cap_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= olt_pkg::IdxW'(16);
    end else begin
      cap_q <= cap_d;
    end
  end

  // Clamp the limit to the table depth
  assign limit = (32'(cap_q) > DEPTH) ? olt_pkg::IdxW'(DEPTH) : cap_q;

  olt_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  olt_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .element_i   (element_i),
    .req_o       (req),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .value_o     (value_o),
    .where_o     (where_o),
    .count_o     (count_o),
    .last_o      (last_o)
  );

endmodule

/* src/olt_mem.sv */
// Entry store of the ordered array table: one write and one read port,
// read data registered. Depends on olt_pkg for the request struct.
module olt_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  olt_pkg::mem_req_t           req_i,
  output logic [olt_pkg::WordW-1:0]   rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [olt_pkg::WordW-1:0] mem_q [DEPTH];
  logic [olt_pkg::WordW-1:0] rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[AW'(req_i.waddr)] <= req_i.wdata;
    end
  end

  // Read one entry; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[AW'(req_i.raddr)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/olt_seq.sv */
// Command sequencer of the ordered array table: decodes a command, walks the
// entry memory a step at a time and drives the result register. Uses olt_pkg.
module olt_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [olt_pkg::IdxW-1:0]    limit_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [olt_pkg::ModeW-1:0]   mode_i,
  input  logic [olt_pkg::IdxW-1:0]    position_i,
  input  logic [olt_pkg::WordW-1:0]   element_i,
  output olt_pkg::mem_req_t           req_o,
  input  logic [olt_pkg::WordW-1:0]   rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [olt_pkg::StatW-1:0]   status_o,
  output logic [olt_pkg::WordW-1:0]   value_o,
  output logic [olt_pkg::IdxW-1:0]    where_o,
  output logic [olt_pkg::IdxW-1:0]    count_o,
  output logic                        last_o
);

  typedef enum logic [3:0] {
    StIdle,
    StInsChk,
    StInsCmp,
    StScanRd,
    StScanCmp,
    StDelChk,
    StDelMv,
    StDispRd,
    StDispCap,
    StEmit
  } state_e;

  state_e                    state_q, state_d;
  olt_pkg::mode_e            mode_q, mode_d;
  logic [olt_pkg::IdxW-1:0]  pos_q, pos_d;
  logic [olt_pkg::WordW-1:0] elem_q, elem_d;
  logic [olt_pkg::IdxW-1:0]  used_q, used_d;
  logic [olt_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [olt_pkg::WordW-1:0] dword_q, dword_d;
  logic [olt_pkg::IdxW-1:0]  dpos_q, dpos_d;
  olt_pkg::res_t             em_q, em_d;
  logic                      out_valid_q, out_valid_d;
  olt_pkg::res_t             out_q, out_d;
  logic [olt_pkg::IdxW-1:0]  out_count_q, out_count_d;

  logic                      full;
  logic                      slot_free;
  logic [olt_pkg::IdxW-1:0]  idx_inc;
  logic [olt_pkg::IdxW-1:0]  idx_dec;
  logic [olt_pkg::IdxW-1:0]  used_inc;
  logic [olt_pkg::IdxW-1:0]  ins_stop;
  olt_pkg::mode_e            mode_in;

  assign full      = used_q >= limit_i;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign idx_inc   = olt_pkg::IdxW'(idx_q + 1'b1);
  assign idx_dec   = olt_pkg::IdxW'(idx_q - 1'b1);
  assign used_inc  = olt_pkg::IdxW'(used_q + 1'b1);
  assign ins_stop  = (mode_q == olt_pkg::ModeSortIns) ? '0 : olt_pkg::IdxW'(pos_q - 1'b1);
  assign mode_in   = olt_pkg::mode_e'(mode_i);

  // Decode, walk the memory and queue results
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    pos_d       = pos_q;
    elem_d      = elem_q;
    used_d      = used_q;
    idx_d       = idx_q;
    dword_d     = dword_q;
    dpos_d      = dpos_q;
    em_d        = em_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    out_count_d = out_count_q;
    req_o       = '0;

    // Drop the result beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          mode_d  = mode_in;
          pos_d   = position_i;
          elem_d  = element_i;
          em_d    = '{status: olt_pkg::StatOk, value: '0, where: '0, last: 1'b1};
          state_d = StEmit;
          case (mode_in)
            olt_pkg::ModeClear: begin
              used_d = '0;
            end
            olt_pkg::ModeAppend: begin
              if (full) begin
                em_d.status = olt_pkg::StatFull;
              end else begin
                req_o.we    = 1'b1;
                req_o.waddr = used_q;
                req_o.wdata = element_i;
                used_d      = used_inc;
              end
            end
            olt_pkg::ModeDisplay: begin
              if (used_q == '0) begin
                em_d.status = olt_pkg::StatEmpty;
              end else begin
                idx_d   = '0;
                state_d = StDispRd;
              end
            end
            olt_pkg::ModeInsAt: begin
              if (full) begin
                em_d.status = olt_pkg::StatFull;
              end else if (position_i == '0 ||
                           {1'b0, position_i} > ({1'b0, used_q} + 1'b1)) begin
                em_d.status = olt_pkg::StatBadPos;
              end else begin
                idx_d   = used_q;
                state_d = StInsChk;
              end
            end
            olt_pkg::ModeSortIns: begin
              if (full) begin
                em_d.status = olt_pkg::StatFull;
              end else begin
                idx_d   = used_q;
                state_d = StInsChk;
              end
            end
            olt_pkg::ModeDelAt: begin
              if (used_q == '0) begin
                em_d.status = olt_pkg::StatEmpty;
              end else if (position_i == '0 || position_i > used_q) begin
                em_d.status = olt_pkg::StatBadPos;
              end else begin
                idx_d   = olt_pkg::IdxW'(position_i - 1'b1);
                state_d = StScanRd;
              end
            end
            olt_pkg::ModeDelVal: begin
              if (used_q == '0) begin
                em_d.status = olt_pkg::StatEmpty;
              end else begin
                idx_d   = '0;
                state_d = StScanRd;
              end
            end
            default: begin
              // unused code: no result
              state_d = StIdle;
            end
          endcase
        end
      end

      // Insert: stop at the target slot or fetch the entry below it
      StInsChk: begin
        if (idx_q == ins_stop) begin
          req_o.we    = 1'b1;
          req_o.waddr = idx_q;
          req_o.wdata = elem_q;
          used_d      = used_inc;
          em_d        = '{status: olt_pkg::StatOk, value: '0, where: '0, last: 1'b1};
          state_d     = StEmit;
        end else begin
          req_o.re    = 1'b1;
          req_o.raddr = idx_dec;
          state_d     = StInsCmp;
        end
      end

      // Insert: shift the fetched entry up, or place the word for sorted insert
      StInsCmp: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        if (mode_q == olt_pkg::ModeSortIns && !($signed(rdata_i) > $signed(elem_q))) begin
          req_o.wdata = elem_q;
          used_d      = used_inc;
          em_d        = '{status: olt_pkg::StatOk, value: '0, where: '0, last: 1'b1};
          state_d     = StEmit;
        end else begin
          req_o.wdata = rdata_i;
          idx_d       = idx_dec;
          state_d     = StInsChk;
        end
      end

      StScanRd: begin
        req_o.re    = 1'b1;
        req_o.raddr = idx_q;
        state_d     = StScanCmp;
      end

      // Delete: take the entry, report not found at the end, or advance the search
      StScanCmp: begin
        if (mode_q == olt_pkg::ModeDelAt || rdata_i == elem_q) begin
          dword_d = rdata_i;
          dpos_d  = idx_inc;
          state_d = StDelChk;
        end else if (idx_inc == used_q) begin
          em_d    = '{status: olt_pkg::StatNotFound, value: '0, where: '0, last: 1'b1};
          state_d = StEmit;
        end else begin
          idx_d   = idx_inc;
          state_d = StScanRd;
        end
      end

      // Delete: close the gap one entry at a time
      StDelChk: begin
        if ({1'b0, idx_q} + 1'b1 >= {1'b0, used_q}) begin
          used_d  = olt_pkg::IdxW'(used_q - 1'b1);
          em_d    = '{status: olt_pkg::StatOk, value: dword_q, where: dpos_q, last: 1'b1};
          state_d = StEmit;
        end else begin
          req_o.re    = 1'b1;
          req_o.raddr = idx_inc;
          state_d     = StDelMv;
        end
      end

      StDelMv: begin
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = rdata_i;
        idx_d       = idx_inc;
        state_d     = StDelChk;
      end

      StDispRd: begin
        req_o.re    = 1'b1;
        req_o.raddr = idx_q;
        state_d     = StDispCap;
      end

      StDispCap: begin
        em_d    = '{status: olt_pkg::StatOk, value: rdata_i, where: idx_inc,
                    last: (idx_inc == used_q)};
        state_d = StEmit;
      end

      // Load the result beat when the register is free
      StEmit: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = em_q;
          out_count_d = used_q;
          if (em_q.last) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_inc;
            state_d = StDispRd;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold state, command and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= olt_pkg::ModeClear;
      pos_q       <= '0;
      elem_q      <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      dword_q     <= '0;
      dpos_q      <= '0;
      em_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      out_count_q <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      elem_q      <= elem_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      dword_q     <= dword_d;
      dpos_q      <= dpos_d;
      em_q        <= em_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      out_count_q <= out_count_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign value_o     = out_q.value;
  assign where_o     = out_q.where;
  assign count_o     = out_count_q;
  assign last_o      = out_q.last;

  // Reads and writes are interlocked: never both in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_o.re && req_o.we))
    else $error("memory read and write issued together");

  // The count never passes the table depth
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DEPTH)
    else $error("entry count beyond depth");

  // Only display results can be followed by more beats of the same command
  a_mid_beat_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last) |-> (out_q.status == olt_pkg::StatOk && out_q.where != '0))
    else $error("non-final beat with error status or no position");

  // While idle with no command offered, the memory sees no access
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && !in_valid_i) |-> (!req_o.re && !req_o.we))
    else $error("memory access while idle");

endmodule

/* sim/ordered_array_table_checker.sv */
// Result checker for the ordered array table: watches the command, result and
// capacity ports, keeps its own copy of the table and compares every result beat.
// Depends on olt_pkg for field widths, command codes and status codes.
module ordered_array_table_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [olt_pkg::IdxW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [olt_pkg::ModeW-1:0] mode_i,
  input  logic [olt_pkg::IdxW-1:0]  position_i,
  input  logic [olt_pkg::WordW-1:0] element_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [olt_pkg::StatW-1:0] status_i,
  input  logic [olt_pkg::WordW-1:0] value_i,
  input  logic [olt_pkg::IdxW-1:0]  where_i,
  input  logic [olt_pkg::IdxW-1:0]  count_i,
  input  logic                      last_i,
  output int unsigned               pending_o,
  output int unsigned               fill_o,
  output int unsigned               errors_o,
  output int unsigned               commands_o,
  output int unsigned               beats_o
);
  import olt_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] value;
    logic [IdxW-1:0]  where;
    logic [IdxW-1:0]  count;
    logic             last;
  } beat_t;

  beat_t                   owed_beats[$];
  logic signed [WordW-1:0] words [DEPTH];
  int unsigned             fill;
  logic [IdxW-1:0]         capacity;
  beat_t                   got_beat;
  beat_t                   want_beat;

  // Entries allowed before the table reports full, clamped to the depth
  function automatic int unsigned room_limit();
    return (capacity > DEPTH) ? DEPTH : capacity;
  endfunction

  function automatic void owe_beat(status_e st, logic [WordW-1:0] val, int unsigned wh,
                                   logic lst);
    beat_t b;
    b.status = st;
    b.value  = val;
    b.where  = IdxW'(wh);
    b.count  = IdxW'(fill);
    b.last   = lst;
    owed_beats.push_back(b);
  endfunction

  // Remove the word at a zero-based slot and close the hole
  function automatic logic [WordW-1:0] take_word(int unsigned idx);
    logic [WordW-1:0] w;
    w = words[idx];
    for (int unsigned j = idx; j + 1 < fill; j++) words[j] = words[j + 1];
    fill--;
    return w;
  endfunction

  // Update the table copy for one command and queue the beats it owes
  function automatic void apply_table_command(logic [ModeW-1:0] md, logic [IdxW-1:0] pos,
                                              logic signed [WordW-1:0] elem);
    bit               full;
    int unsigned      slot;
    logic [WordW-1:0] w;
    full = fill >= room_limit();
    case (md)
      ModeClear: begin
        fill = 0;
        owe_beat(StatOk, '0, 0, 1'b1);
      end
      ModeAppend: begin
        if (full) owe_beat(StatFull, '0, 0, 1'b1);
        else begin
          words[fill] = elem;
          fill++;
          owe_beat(StatOk, '0, 0, 1'b1);
        end
      end
      ModeDisplay: begin
        if (fill == 0) owe_beat(StatEmpty, '0, 0, 1'b1);
        else begin
          for (slot = 0; slot < fill; slot++)
            owe_beat(StatOk, words[slot], slot + 1, slot + 1 == fill);
        end
      end
      ModeInsAt: begin
        if (full) owe_beat(StatFull, '0, 0, 1'b1);
        else if (pos < 1 || pos > fill + 1) owe_beat(StatBadPos, '0, 0, 1'b1);
        else begin
          for (slot = fill; slot >= pos; slot--) words[slot] = words[slot - 1];
          words[pos - 1] = elem;
          fill++;
          owe_beat(StatOk, '0, 0, 1'b1);
        end
      end
      ModeDelAt: begin
        if (fill == 0) owe_beat(StatEmpty, '0, 0, 1'b1);
        else if (pos < 1 || pos > fill) owe_beat(StatBadPos, '0, 0, 1'b1);
        else begin
          w = take_word(pos - 1);
          owe_beat(StatOk, w, pos, 1'b1);
        end
      end
      ModeSortIns: begin
        if (full) owe_beat(StatFull, '0, 0, 1'b1);
        else begin
          // shift up every entry greater than the new word, signed
          slot = fill;
          while (slot > 0 && words[slot - 1] > elem) begin
            words[slot] = words[slot - 1];
            slot--;
          end
          words[slot] = elem;
          fill++;
          owe_beat(StatOk, '0, 0, 1'b1);
        end
      end
      ModeDelVal: begin
        if (fill == 0) owe_beat(StatEmpty, '0, 0, 1'b1);
        else begin
          slot = 0;
          while (slot < fill && words[slot] != elem) slot++;
          if (slot == fill) owe_beat(StatNotFound, '0, 0, 1'b1);
          else begin
            w = take_word(slot);
            owe_beat(StatOk, w, slot + 1, 1'b1);
          end
        end
      end
      // unused code: no result
      default: ;
    endcase
  endfunction

  // Compare result beats first, then take capacity writes and commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_beats.delete();
      fill       = 0;
      capacity   = 5'd16;
      errors_o   = 0;
      commands_o = 0;
      beats_o    = 0;
      pending_o  = 0;
      fill_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got_beat.status = status_e'(status_i);
        got_beat.value  = value_i;
        got_beat.where  = where_i;
        got_beat.count  = count_i;
        got_beat.last   = last_i;
        beats_o++;
        if (owed_beats.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result beat with none owed: status=%0d value=%h where=%0d",
                     $time, status_i, value_i, where_i, " count=%0d last=%0b",
                     count_i, last_i);
        end else begin
          want_beat = owed_beats.pop_front();
          if (got_beat.status != want_beat.status || got_beat.value != want_beat.value ||
              got_beat.where != want_beat.where || got_beat.count != want_beat.count ||
              got_beat.last != want_beat.last) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: beat mismatch: expected status=%0d value=%h where=%0d", $time,
                       want_beat.status, want_beat.value, want_beat.where,
                       " count=%0d last=%0b, got status=%0d value=%h where=%0d",
                       want_beat.count, want_beat.last, status_i, value_i, where_i,
                       " count=%0d last=%0b", count_i, last_i);
          end
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        commands_o++;
        apply_table_command(mode_i, position_i, element_i);
      end
      pending_o = owed_beats.size();
      fill_o    = fill;
    end
  end

endmodule

/* sim/ordered_array_table_tb.sv */
// Top of the ordered array table testbench: clock, reset, command stimulus,
// receiver stalls and the verdict. Depends on olt_pkg, the table RTL and
// ordered_array_table_checker, which does all prediction and comparison.
module ordered_array_table_tb;
  import olt_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 2 * DEPTH + 8;
  localparam int unsigned PhaseItems  = 43;
  localparam int unsigned PhaseCount  = 10;
  localparam logic [ModeW-1:0] ModeUnused = 3'd7;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_style_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [IdxW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ModeW-1:0]  mode_i      = '0;
  logic [IdxW-1:0]   position_i  = '0;
  logic [WordW-1:0]  element_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [StatW-1:0]  status_o;
  logic [WordW-1:0]  value_o;
  logic [IdxW-1:0]   where_o;
  logic [IdxW-1:0]   count_o;
  logic              last_o;

  int unsigned       pending;
  int unsigned       table_fill;
  int unsigned       errors;
  int unsigned       commands;
  int unsigned       beats;

  int unsigned       cycle_count       = 0;
  int unsigned       burst_left        = 0;
  int unsigned       capacity_settings = 0;
  int unsigned       style_left        = 0;
  stall_style_e      stall_style       = StallNone;
  logic [WordW-1:0]  word_pool [8];
  logic [IdxW-1:0]   capacity_plan [PhaseCount] =
    '{5'd16, 5'd1, 5'd7, 5'd0, 5'd31, 5'd16, 5'd3, 5'd20, 5'd12, 5'd16};

  ordered_array_table #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .position_i (position_i),
    .element_i  (element_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .value_o    (value_o),
    .where_o    (where_o),
    .count_o    (count_o),
    .last_o     (last_o)
  );

  ordered_array_table_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .mode_i     (mode_i),
    .position_i (position_i),
    .element_i  (element_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status_o),
    .value_i    (value_o),
    .where_i    (where_o),
    .count_i    (count_o),
    .last_i     (last_o),
    .pending_o  (pending),
    .fill_o     (table_fill),
    .errors_o   (errors),
    .commands_o (commands),
    .beats_o    (beats)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d beats still owed", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls: switch at random between four styles
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      style_left  = $urandom_range(40, 300);
    end
    style_left--;
    case (stall_style)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ((style_left % 7) < 3);
    endcase
  end

  // Mostly words from a small pool so that searches and sorts find equal entries
  function automatic logic [WordW-1:0] pick_word();
    if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Mostly a position inside the table, sometimes any 5-bit value
  function automatic logic [IdxW-1:0] pick_spot(int unsigned hi);
    if (hi == 0 || $urandom_range(0, 99) < 15) return IdxW'($urandom);
    return IdxW'($urandom_range(1, hi));
  endfunction

  // Present one command beat and hold it until taken; end bursts with a gap
  task automatic send_beat(logic [ModeW-1:0] md, logic [IdxW-1:0] pos,
                           logic [WordW-1:0] elem);
    int unsigned gap;
    in_valid_i <= 1'b1;
    mode_i     <= md;
    position_i <= pos;
    element_i  <= elem;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Hold off the sender until every owed beat has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Write capacity only with the table idle
  task automatic set_capacity(logic [IdxW-1:0] cap);
    drain();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity_settings++;
  endtask

  // Random command, weighted towards filling the table
  task automatic send_random();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) send_beat(ModeClear, IdxW'($urandom), pick_word());
    else if (roll < 28) send_beat(ModeAppend, IdxW'($urandom), pick_word());
    else if (roll < 36) send_beat(ModeDisplay, IdxW'($urandom), pick_word());
    else if (roll < 51) send_beat(ModeInsAt, pick_spot(table_fill + 1), pick_word());
    else if (roll < 63) send_beat(ModeDelAt, pick_spot(table_fill), pick_word());
    else if (roll < 81) send_beat(ModeSortIns, IdxW'($urandom), pick_word());
    else if (roll < 96) send_beat(ModeDelVal, IdxW'($urandom), pick_word());
    else if (roll < 98) send_beat(ModeUnused, IdxW'($urandom), pick_word());
    else send_beat(ModeW'($urandom), IdxW'($urandom), $urandom);
  endtask

  initial begin
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;
    word_pool[2] = 32'h7FFF_FFFF;
    word_pool[3] = 32'h8000_0000;
    for (int k = 4; k < 8; k++) word_pool[k] = $urandom;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, extremes, bad positions, sorted placement, search
    send_beat(ModeDisplay, '0, '0);
    send_beat(ModeDelAt, 5'd1, '0);
    send_beat(ModeDelVal, '0, 32'd0);
    send_beat(ModeAppend, '0, 32'h7FFF_FFFF);
    send_beat(ModeAppend, 5'd31, 32'h8000_0000);
    send_beat(ModeInsAt, 5'd0, 32'd9);
    send_beat(ModeInsAt, 5'd1, 32'hFFFF_FFFF);
    send_beat(ModeInsAt, 5'd4, 32'd0);
    send_beat(ModeInsAt, 5'd31, 32'd9);
    send_beat(ModeSortIns, '0, 32'd5);
    send_beat(ModeSortIns, '0, 32'h8000_0000);
    send_beat(ModeDelAt, 5'd31, '0);
    send_beat(ModeDelAt, 5'd0, '0);
    send_beat(ModeDelAt, 5'd6, '0);
    send_beat(ModeDelAt, 5'd1, '0);
    send_beat(ModeDelVal, '0, 32'd0);
    send_beat(ModeDelVal, '0, 32'd123);
    send_beat(ModeUnused, 5'd17, 32'hA5A5_5A5A);
    send_beat(ModeDisplay, '0, '0);
    send_beat(ModeClear, '0, '0);

    // Small capacity: fill it, then full on every growing command, then capacity below the count
    set_capacity(5'd2);
    send_beat(ModeAppend, '0, 32'd1);
    send_beat(ModeAppend, '0, 32'd2);
    send_beat(ModeAppend, '0, 32'd3);
    send_beat(ModeInsAt, 5'd1, 32'd4);
    send_beat(ModeSortIns, '0, 32'd5);
    set_capacity(5'd1);
    send_beat(ModeAppend, '0, 32'd6);
    send_beat(ModeDisplay, '0, '0);

    // Random phases, one capacity each; drain mid-phase once
    for (int p = 0; p < PhaseCount; p++) begin
      set_capacity(capacity_plan[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == PhaseItems / 2) drain();
        send_random();
      end
    end

    drain();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Sent %0d commands and checked %0d result beats over %0d capacity writes",
             commands, beats, capacity_settings);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatching beats, %0d beats never seen", errors, pending);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
